// ===== hdl/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// srp_pkg
// Types and constants for the shelf rectangle packer.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int DIM_BITS        = 14;
  localparam int GROW_BITS       = DIM_BITS + 1;
  localparam int REG_W           = 15;
  localparam int PAD_W           = 8;
  localparam int PCT_W           = 7;
  localparam int GLYPH_W         = 12;
  localparam int CUR_W           = 17;
  localparam int ROW_W           = 13;
  localparam int STEP_W          = 6;
  localparam int MUL_A_W         = 18;
  localparam int MUL_P_W         = MUL_A_W + PCT_W;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 32;

  localparam logic [STEP_W-1:0] GROW_STEP_LIMIT = STEP_W'(32);
  localparam logic [PCT_W-1:0]  PCT_SCALE       = PCT_W'(100);

  localparam logic [REG_W-1:0]  ATLAS_W_RST     = REG_W'(512);
  localparam logic [REG_W-1:0]  ATLAS_H_RST     = REG_W'(512);
  localparam logic [REG_W-1:0]  MAX_DIM_RST     = REG_W'(4096);
  localparam logic [PAD_W-1:0]  PADDING_RST     = PAD_W'(1);
  localparam logic [PCT_W-1:0]  HEADROOM_RST    = PCT_W'(75);

  typedef enum logic [2:0] {
    REG_ATLAS_W  = 3'd0,
    REG_ATLAS_H  = 3'd1,
    REG_MAX_DIM  = 3'd2,
    REG_PADDING  = 3'd3,
    REG_HEADROOM = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC_A,
    ST_ALLOC_B,
    ST_ALLOC_C,
    ST_GROW,
    ST_PRESS_1,
    ST_PRESS_2,
    ST_PRESS_3,
    ST_DONE
  } srp_state_t;

endpackage

// ===== hdl/shelf_rect_packer.sv =====
// ----------------------------------------------------------------------------
// shelf_rect_packer
// Shelf allocator for glyph rectangles in a 2D atlas, with growth search.
// ----------------------------------------------------------------------------
// Input beat: in_kind 0 allocates a glyph of in_glyph_width x in_glyph_height,
// in_kind 1 restarts the shelves. Each input beat gives exactly one output
// beat: placement (out_placed, out_pos_x, out_pos_y), a suggested grown atlas
// size when the glyph did not fit, and the fill-pressure flag.
// Settings must be written over the APB-style cfg_ port only while the block
// is idle (the block itself does not enforce this); they take effect for the next beat.
// One item at a time: in_ready drops for the duration of the sequence.
// A restart passes ALLOC_A, the three PRESS states and DONE; a placed glyph
// also passes ALLOC_B and ALLOC_C. Failed allocation: one growth step per
// cycle, at most 32 steps, on two dimension-step units, one per dimension;
// pressure uses one shared 18x7 multiplier in PRESS_1 and PRESS_2.
// The output register lets the next input beat be taken while a result waits;
// that item then holds in its last state until the output register frees.
// Reset (rst_n low, synchronous) restores the register defaults, puts the
// shelf cursor at (1, 1) with an empty row and empties the output register.
// ----------------------------------------------------------------------------
module shelf_rect_packer
  import srp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_kind,
  input  logic [GLYPH_W-1:0]       in_glyph_width,
  input  logic [GLYPH_W-1:0]       in_glyph_height,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_placed,
  output logic [DIM_BITS-1:0]      out_pos_x,
  output logic [DIM_BITS-1:0]      out_pos_y,
  output logic                     out_grow_found,
  output logic [GROW_BITS-1:0]     out_grow_width,
  output logic [GROW_BITS-1:0]     out_grow_height,
  output logic                     out_pressure_high,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [CFG_DATA_W-1:0]    cfg_prdata,
  output logic                     cfg_pready
);

  // configuration
  logic [REG_W-1:0] atlas_w_r, atlas_h_r, max_dim_r;
  logic [PAD_W-1:0] padding_r;
  logic [PCT_W-1:0] headroom_r;
  cfg_reg_t         cfg_idx;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r  <= ATLAS_W_RST;
      atlas_h_r  <= ATLAS_H_RST;
      max_dim_r  <= MAX_DIM_RST;
      padding_r  <= PADDING_RST;
      headroom_r <= HEADROOM_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ATLAS_W:  atlas_w_r  <= cfg_pwdata[REG_W-1:0];
        REG_ATLAS_H:  atlas_h_r  <= cfg_pwdata[REG_W-1:0];
        REG_MAX_DIM:  max_dim_r  <= cfg_pwdata[REG_W-1:0];
        REG_PADDING:  padding_r  <= cfg_pwdata[PAD_W-1:0];
        REG_HEADROOM: headroom_r <= cfg_pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ATLAS_W:  cfg_prdata = CFG_DATA_W'(atlas_w_r);
      REG_ATLAS_H:  cfg_prdata = CFG_DATA_W'(atlas_h_r);
      REG_MAX_DIM:  cfg_prdata = CFG_DATA_W'(max_dim_r);
      REG_PADDING:  cfg_prdata = CFG_DATA_W'(padding_r);
      REG_HEADROOM: cfg_prdata = CFG_DATA_W'(headroom_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // effective cap, zero acts as one
  logic [REG_W-1:0] max_eff;
  assign max_eff = (max_dim_r == '0) ? REG_W'(1) : max_dim_r;

  // sequencer
  srp_state_t state_r, state_nxt;

  logic                 kind_r;
  logic [GLYPH_W-1:0]   gw_r, gh_r;
  logic [ROW_W-1:0]     cw_r, ch_r;
  logic                 fits_r, newsh_r;
  logic [CUR_W:0]       ynew_r;
  logic [CUR_W-1:0]     cursor_x_r, cursor_y_r;
  logic [ROW_W-1:0]     row_h_r;
  logic [REG_W-1:0]     nw_r, nh_r;
  logic [STEP_W-1:0]    step_r;
  logic [MUL_P_W-1:0]   prod_a_r, prod_b_r;

  logic                 res_placed_r, res_found_r;
  logic [DIM_BITS-1:0]  res_px_r, res_py_r;
  logic [GROW_BITS-1:0] res_gw_r, res_gh_r;
  logic                 res_press_r;

  logic                 out_valid_r, out_placed_r, out_found_r, out_press_r;
  logic [DIM_BITS-1:0]  out_px_r, out_py_r;
  logic [GROW_BITS-1:0] out_gw_r, out_gh_r;

  logic in_fire, out_load;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // allocation datapath
  logic [CUR_W-1:0]   y_sel, cx_base;
  logic [CUR_W+1:0]   y_bottom;
  logic               alloc_ok;
  logic [ROW_W-1:0]   row_base;

  assign y_sel    = newsh_r ? ynew_r[CUR_W-1:0] : cursor_y_r;
  assign y_bottom = (CUR_W+2)'(y_sel) + (CUR_W+2)'(ch_r) + (CUR_W+2)'(padding_r);
  assign alloc_ok = fits_r && (y_bottom <= (CUR_W+2)'(atlas_h_r));
  assign cx_base  = newsh_r ? CUR_W'(padding_r) : cursor_x_r;
  assign row_base = newsh_r ? '0 : row_h_r;

  // dimension-step unit, one instance per dimension
  function automatic logic [REG_W-1:0] dim_step(
    input logic [REG_W-1:0] n,
    input logic [PAD_W+1:0] p4,
    input logic [REG_W-2:0] need,
    input logic [REG_W-1:0] mx
  );
    logic [REG_W-1:0] base;
    logic [REG_W+1:0] dbl, grown;
    base  = (n > REG_W'(p4)) ? n : REG_W'(p4);
    dbl   = {1'b0, base, 1'b0};
    grown = (dbl > (REG_W+2)'(need)) ? dbl : (REG_W+2)'(need);
    dim_step = (grown < (REG_W+2)'(mx)) ? grown[REG_W-1:0] : mx;
  endfunction

  logic [PAD_W+1:0] pad4;
  logic [REG_W-2:0] need_w, need_h;
  logic [REG_W-1:0] nw_step, nh_step;
  logic             grow_cont, grow_fit;

  assign pad4      = {padding_r, 2'b00};
  assign need_w    = (REG_W-1)'(cw_r) + (REG_W-1)'(padding_r);
  assign need_h    = (REG_W-1)'(ch_r) + (REG_W-1)'(padding_r);
  assign nw_step   = dim_step(nw_r, pad4, need_w, max_eff);
  assign nh_step   = dim_step(nh_r, pad4, need_h, max_eff);
  assign grow_cont = ((nw_r < max_eff) || (nh_r < max_eff)) && (step_r < GROW_STEP_LIMIT);
  assign grow_fit  = (REG_W'(cw_r) < nw_step) && (REG_W'(ch_r) < nh_step);

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [PCT_W-1:0]   mul_b;
  logic [MUL_P_W-1:0] mul_p;

  always_comb begin
    if (state_r == ST_PRESS_1) begin
      mul_a = MUL_A_W'(cursor_y_r) + MUL_A_W'(row_h_r);
      mul_b = PCT_SCALE;
    end else begin
      mul_a = MUL_A_W'(atlas_h_r);
      mul_b = headroom_r;
    end
    mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_ALLOC_A;
      ST_ALLOC_A: state_nxt = kind_r ? ST_PRESS_1 : ST_ALLOC_B;
      ST_ALLOC_B: state_nxt = ST_ALLOC_C;
      ST_ALLOC_C: state_nxt = alloc_ok ? ST_PRESS_1 : ST_GROW;
      ST_GROW:    if (!grow_cont || grow_fit) state_nxt = ST_PRESS_1;
      ST_PRESS_1: state_nxt = ST_PRESS_2;
      ST_PRESS_2: state_nxt = ST_PRESS_3;
      ST_PRESS_3: state_nxt = ST_DONE;
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // shelf state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= CUR_W'(PADDING_RST);
      cursor_y_r <= CUR_W'(PADDING_RST);
      row_h_r    <= '0;
    end else if (state_r == ST_ALLOC_A && kind_r) begin
      cursor_x_r <= CUR_W'(padding_r);
      cursor_y_r <= CUR_W'(padding_r);
      row_h_r    <= '0;
    end else if (state_r == ST_ALLOC_C && alloc_ok) begin
      cursor_y_r <= y_sel;
      cursor_x_r <= cx_base + CUR_W'(cw_r) + CUR_W'(padding_r);
      row_h_r    <= (row_base > ch_r) ? row_base : ch_r;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        kind_r <= in_kind;
        gw_r   <= in_glyph_width;
        gh_r   <= in_glyph_height;
      end
      ST_ALLOC_A: begin
        cw_r         <= ROW_W'(gw_r) + ROW_W'({padding_r, 1'b0});
        ch_r         <= ROW_W'(gh_r) + ROW_W'({padding_r, 1'b0});
        res_placed_r <= 1'b0;
        res_px_r     <= '0;
        res_py_r     <= '0;
        res_found_r  <= 1'b0;
        res_gw_r     <= '0;
        res_gh_r     <= '0;
      end
      ST_ALLOC_B: begin
        fits_r  <= (REG_W'(cw_r) < atlas_w_r) && (REG_W'(ch_r) < atlas_h_r);
        newsh_r <= ((CUR_W+1)'(cursor_x_r) + (CUR_W+1)'(cw_r) + (CUR_W+1)'(padding_r))
                   > (CUR_W+1)'(atlas_w_r);
        ynew_r  <= (CUR_W+1)'(cursor_y_r) + (CUR_W+1)'(row_h_r) + (CUR_W+1)'(padding_r);
      end
      ST_ALLOC_C: begin
        if (alloc_ok) begin
          res_placed_r <= 1'b1;
          res_px_r     <= DIM_BITS'(cx_base + CUR_W'(padding_r));
          res_py_r     <= DIM_BITS'(y_sel + CUR_W'(padding_r));
        end
        nw_r   <= atlas_w_r;
        nh_r   <= atlas_h_r;
        step_r <= '0;
      end
      ST_GROW: begin
        if (grow_cont) begin
          nw_r   <= nw_step;
          nh_r   <= nh_step;
          step_r <= step_r + STEP_W'(1);
          if (grow_fit) begin
            res_found_r <= 1'b1;
            res_gw_r    <= GROW_BITS'(nw_step);
            res_gh_r    <= GROW_BITS'(nh_step);
          end
        end
      end
      ST_PRESS_1: prod_a_r <= mul_p;
      ST_PRESS_2: prod_b_r <= mul_p;
      ST_PRESS_3: begin
        res_press_r <= !((atlas_w_r >= max_eff) || (atlas_h_r >= max_eff))
                       && (prod_a_r > prod_b_r);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_placed_r <= res_placed_r;
      out_px_r     <= res_px_r;
      out_py_r     <= res_py_r;
      out_found_r  <= res_found_r;
      out_gw_r     <= res_gw_r;
      out_gh_r     <= res_gh_r;
      out_press_r  <= res_press_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_placed        = out_placed_r;
  assign out_pos_x         = out_px_r;
  assign out_pos_y         = out_py_r;
  assign out_grow_found    = out_found_r;
  assign out_grow_width    = out_gw_r;
  assign out_grow_height   = out_gh_r;
  assign out_pressure_high = out_press_r;

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input beat taken while busy");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GROW) |-> (step_r <= GROW_STEP_LIMIT))
    else $error("growth search ran past its step limit");

  a_place_xor_grow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_placed_r && out_found_r))
    else $error("result both placed and grown");

  a_no_grow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_gw_r == '0 && out_gh_r == '0))
    else $error("grow size without a found size");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");
`endif

endmodule
